// ----- design/gwm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the Gaussian-window MACD block
// Fixed field widths, fixed-point formats, divider sizing and FSM states.
// ---------------------------------------------------------------------------
package gwm_pkg;

  localparam int PRICE_W   = 32;                 // Q24.8 price
  localparam int FRAC_W    = 24;                 // weight and ratio fraction bits
  localparam int WEIGHT_W  = FRAC_W + 1;         // Q1.24 weight, 1.0 fits
  localparam int PROD_W    = PRICE_W + WEIGHT_W;
  localparam int ACC_W     = 64;
  localparam int RATIO_W   = 32;                 // signed Q7.24
  localparam int QUO_W     = RATIO_W - 1;        // magnitude bits below saturation
  localparam int SAT_SHIFT = QUO_W - FRAC_W;     // quotient >= 2^31 iff diff >= l << 7
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int Q30_W     = 30;

  localparam logic [63:0]        Q30_ONE   = 64'd1 << Q30_W;
  localparam logic [ACC_W-1:0]   ROUND_BIT = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [RATIO_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 32'h8000_0000;
  localparam logic [PRICE_W-1:0] AVG_MAX   = 32'hFFFF_FFFF;

  typedef logic [PRICE_W-1:0] price_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } gwm_state_t;

endpackage

// ----- design/gaussian_window_macd.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_window_macd: Gaussian-weighted MACD ratio over a price window
// Price window in a synchronous RAM, MAC walk over the window, bit-serial
// divider for the ratio.
// ---------------------------------------------------------------------------
// Each transfer writes one Q24.8 price into a LONG_TAPS deep circular RAM. Until
// the window is full a transfer is only written and gives no result.
// After that every transfer starts a walk over the RAM from the oldest price,
// one read per cycle, feeding two multiply-accumulate lanes (long and short
// Gaussian weights from elaboration-time tables), then rounding, then a 31-step
// restoring divider for (short - long) / long. A saturated or zero-divisor
// ratio skips the divider. One item is in flight at a time; in_ready is high
// between items, also while a finished result waits in the output register.
// ---------------------------------------------------------------------------
module gaussian_window_macd #(
  parameter int LONG_TAPS  = 26,
  parameter int SHORT_TAPS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_close_price,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_short_average,
  output logic [31:0]                out_long_average,
  output logic signed [31:0]         out_macd_ratio,
  output logic                       out_divide_fault
);

  localparam int SHORT_USED = (SHORT_TAPS < LONG_TAPS) ? SHORT_TAPS : LONG_TAPS;
  localparam int TAP_W      = $clog2(LONG_TAPS);
  localparam int FILL_W     = $clog2(LONG_TAPS + 1);
  localparam int WW         = gwm_pkg::WEIGHT_W;

  localparam logic [TAP_W-1:0]  TAP_LAST  = TAP_W'(LONG_TAPS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LONG_TAPS);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LONG_TAPS - 1);

  localparam logic [63:0] LongSq  = 64'(LONG_TAPS) * 64'(LONG_TAPS);
  localparam logic [63:0] ShortSq = 64'(SHORT_USED) * 64'(SHORT_USED);

  // ---------------------------------------------------------------------------
  // Weight tables, evaluated at elaboration only
  // ---------------------------------------------------------------------------
  // exp(-3 k^2 / n^2) in Q30: Taylor series of exp(-x/8), then squared 3 times
  function automatic logic [63:0] gauss_q30(input logic [63:0] k, input logic is_short);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] t;
    if (is_short) x = ((64'd3 * k * k) << gwm_pkg::Q30_W) / ShortSq;
    else          x = ((64'd3 * k * k) << gwm_pkg::Q30_W) / LongSq;
    y = x >> 3;
    r = gwm_pkg::Q30_ONE;
    t = gwm_pkg::Q30_ONE;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd1;  r = r - t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd2;  r = r + t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd3;  r = r - t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd4;  r = r + t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd5;  r = r - t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd6;  r = r + t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd7;  r = r - t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd8;  r = r + t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd9;  r = r - t;
    t = ((t * y) >> gwm_pkg::Q30_W) / 64'd10; r = r + t;
    r = (r * r) >> gwm_pkg::Q30_W;
    r = (r * r) >> gwm_pkg::Q30_W;
    r = (r * r) >> gwm_pkg::Q30_W;
    return r;
  endfunction

  function automatic logic [63:0] gauss_sum(input logic is_short);
    logic [63:0] sum;
    int          n;
    sum = '0;
    n   = is_short ? SHORT_USED : LONG_TAPS;
    for (int k = 0; k < LONG_TAPS; k++) begin
      if (k < n) sum = sum + gauss_q30(64'(k), is_short);
    end
    return sum;
  endfunction

  localparam logic [63:0] LongSum  = gauss_sum(1'b0);
  localparam logic [63:0] ShortSum = gauss_sum(1'b1);

  // normalized Q1.24 weights, oldest price at index 0, zero past the tap count
  function automatic logic [LONG_TAPS*WW-1:0] build_weights(input logic is_short);
    logic [LONG_TAPS*WW-1:0] tbl;
    logic [63:0]             raw;
    logic [63:0]             w;
    int                      n;
    tbl = '0;
    n   = is_short ? SHORT_USED : LONG_TAPS;
    for (int k = 0; k < LONG_TAPS; k++) begin
      if (k < n) begin
        raw = gauss_q30(64'(k), is_short);
        if (is_short) w = ((raw << gwm_pkg::FRAC_W) + (ShortSum >> 1)) / ShortSum;
        else          w = ((raw << gwm_pkg::FRAC_W) + (LongSum >> 1)) / LongSum;
        tbl[k*WW +: WW] = w[WW-1:0];
      end
    end
    return tbl;
  endfunction

  localparam logic [LONG_TAPS*WW-1:0] LongWeights  = build_weights(1'b0);
  localparam logic [LONG_TAPS*WW-1:0] ShortWeights = build_weights(1'b1);

  function automatic gwm_pkg::price_t round_sat(input logic [gwm_pkg::ACC_W-1:0] acc);
    logic [gwm_pkg::ACC_W-1:0]              sum;
    logic [gwm_pkg::ACC_W-gwm_pkg::FRAC_W-1:0] q;
    sum = acc + gwm_pkg::ROUND_BIT;
    q   = sum[gwm_pkg::ACC_W-1:gwm_pkg::FRAC_W];
    if (|q[$bits(q)-1:gwm_pkg::PRICE_W]) return gwm_pkg::AVG_MAX;
    return q[gwm_pkg::PRICE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  gwm_pkg::gwm_state_t state_r, state_nxt;

  logic [TAP_W-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TAP_W-1:0]  tap_cnt_r, tap_cnt_nxt;

  gwm_pkg::price_t   price_mem [LONG_TAPS];
  gwm_pkg::price_t   rd_data_r;
  logic [TAP_W:0]    addr_sum;
  logic [TAP_W-1:0]  rd_addr;
  logic              wr_en;
  logic              acc_clr;

  logic                        rd_vld_r;
  logic                        prod_vld_r;
  logic [WW-1:0]               wl_r;
  logic [WW-1:0]               ws_r;
  logic [gwm_pkg::PROD_W-1:0]  prod_l_r;
  logic [gwm_pkg::PROD_W-1:0]  prod_s_r;
  logic [gwm_pkg::ACC_W-1:0]   acc_l_r;
  logic [gwm_pkg::ACC_W-1:0]   acc_s_r;

  gwm_pkg::price_t avg_s_r, avg_s_nxt;
  gwm_pkg::price_t avg_l_r, avg_l_nxt;
  logic            neg_r, neg_nxt;
  logic            sat_r, sat_nxt;
  logic            fault_r, fault_nxt;

  gwm_pkg::price_t              rem_r, rem_nxt;
  logic [gwm_pkg::QUO_W-1:0]    low_r, low_nxt;
  logic [gwm_pkg::QUO_W-1:0]    quo_r, quo_nxt;
  logic [gwm_pkg::DIV_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  gwm_pkg::price_t diff;
  logic [gwm_pkg::PRICE_W:0]    trial;
  logic [gwm_pkg::RATIO_W-1:0]  ratio_mag;

  logic                         out_valid_r, out_valid_nxt;
  gwm_pkg::price_t              out_short_r, out_short_nxt;
  gwm_pkg::price_t              out_long_r, out_long_nxt;
  logic [gwm_pkg::RATIO_W-1:0]  out_ratio_r, out_ratio_nxt;
  logic                         out_fault_r, out_fault_nxt;

  // ---------------------------------------------------------------------------
  // Price RAM: one write port, one registered read port
  // ---------------------------------------------------------------------------
  // oldest price sits at wp_r once the window is full
  always_comb begin
    addr_sum = {1'b0, wp_r} + {1'b0, tap_cnt_r};
    if (addr_sum >= (TAP_W + 1)'(LONG_TAPS)) addr_sum = addr_sum - (TAP_W + 1)'(LONG_TAPS);
    rd_addr = addr_sum[TAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) price_mem[wp_r] <= in_close_price;
    rd_data_r <= price_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // MAC lanes: weight aligned with RAM data, product register, accumulate
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= (state_r == gwm_pkg::ST_MAC);
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    wl_r     <= LongWeights[tap_cnt_r*WW +: WW];
    ws_r     <= ShortWeights[tap_cnt_r*WW +: WW];
    prod_l_r <= gwm_pkg::PROD_W'(rd_data_r) * gwm_pkg::PROD_W'(wl_r);
    prod_s_r <= gwm_pkg::PROD_W'(rd_data_r) * gwm_pkg::PROD_W'(ws_r);
    if (acc_clr) begin
      acc_l_r <= '0;
      acc_s_r <= '0;
    end else if (prod_vld_r) begin
      acc_l_r <= acc_l_r + gwm_pkg::ACC_W'(prod_l_r);
      acc_s_r <= acc_s_r + gwm_pkg::ACC_W'(prod_s_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Control FSM, rounding and restoring divider
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    tap_cnt_nxt   = tap_cnt_r;
    avg_s_nxt     = avg_s_r;
    avg_l_nxt     = avg_l_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    fault_nxt     = fault_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quo_nxt       = quo_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_short_nxt = out_short_r;
    out_long_nxt  = out_long_r;
    out_ratio_nxt = out_ratio_r;
    out_fault_nxt = out_fault_r;
    wr_en         = 1'b0;
    acc_clr       = 1'b0;
    diff          = neg_r ? (avg_l_r - avg_s_r) : (avg_s_r - avg_l_r);
    trial         = {rem_r, low_r[gwm_pkg::QUO_W-1]};
    ratio_mag     = {1'b0, quo_r};

    unique case (state_r)
      gwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          wr_en  = 1'b1;
          wp_nxt = (wp_r == TAP_LAST) ? '0 : wp_r + 1'b1;
          if (fill_r != FILL_FULL) fill_nxt = fill_r + 1'b1;
          if (fill_r >= FILL_LAST) begin
            acc_clr     = 1'b1;
            tap_cnt_nxt = '0;
            state_nxt   = gwm_pkg::ST_MAC;
          end
        end
      end
      gwm_pkg::ST_MAC: begin
        if (tap_cnt_r == TAP_LAST) state_nxt = gwm_pkg::ST_DRAIN;
        else                       tap_cnt_nxt = tap_cnt_r + 1'b1;
      end
      gwm_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) state_nxt = gwm_pkg::ST_ROUND;
      end
      gwm_pkg::ST_ROUND: begin
        avg_s_nxt = round_sat(acc_s_r);
        avg_l_nxt = round_sat(acc_l_r);
        state_nxt = gwm_pkg::ST_PREP;
      end
      gwm_pkg::ST_PREP: begin
        fault_nxt = (avg_l_r == '0);
        neg_nxt   = (avg_s_r < avg_l_r);
        diff      = neg_nxt ? (avg_l_r - avg_s_r) : (avg_s_r - avg_l_r);
        // quotient would reach 2^31: saturate without dividing
        sat_nxt   = {gwm_pkg::SAT_SHIFT'(0), diff} >= {avg_l_r, gwm_pkg::SAT_SHIFT'(0)};
        // dividend is diff << 24; its top bits are already below the divisor
        rem_nxt   = {gwm_pkg::SAT_SHIFT'(0), diff[gwm_pkg::PRICE_W-1:gwm_pkg::SAT_SHIFT]};
        low_nxt   = {diff[gwm_pkg::SAT_SHIFT-1:0], gwm_pkg::FRAC_W'(0)};
        quo_nxt   = '0;
        bit_cnt_nxt = gwm_pkg::DIV_CNT_W'(gwm_pkg::QUO_W - 1);
        state_nxt = (fault_nxt || sat_nxt) ? gwm_pkg::ST_DONE : gwm_pkg::ST_DIV;
      end
      gwm_pkg::ST_DIV: begin
        if (trial >= {1'b0, avg_l_r}) begin
          rem_nxt = gwm_pkg::PRICE_W'(trial - {1'b0, avg_l_r});
          quo_nxt = {quo_r[gwm_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[gwm_pkg::PRICE_W-1:0];
          quo_nxt = {quo_r[gwm_pkg::QUO_W-2:0], 1'b0};
        end
        low_nxt = low_r << 1;
        if (bit_cnt_r == '0) state_nxt = gwm_pkg::ST_DONE;
        else                 bit_cnt_nxt = bit_cnt_r - 1'b1;
      end
      gwm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_short_nxt = avg_s_r;
          out_long_nxt  = avg_l_r;
          out_fault_nxt = fault_r;
          priority if (fault_r) out_ratio_nxt = '0;
          else if (sat_r)       out_ratio_nxt = neg_r ? gwm_pkg::RATIO_MIN : gwm_pkg::RATIO_MAX;
          else                  out_ratio_nxt = neg_r ? (~ratio_mag + 1'b1) : ratio_mag;
          state_nxt = gwm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gwm_pkg::ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_cnt_r   <= tap_cnt_nxt;
    avg_s_r     <= avg_s_nxt;
    avg_l_r     <= avg_l_nxt;
    neg_r       <= neg_nxt;
    sat_r       <= sat_nxt;
    fault_r     <= fault_nxt;
    rem_r       <= rem_nxt;
    low_r       <= low_nxt;
    quo_r       <= quo_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    out_short_r <= out_short_nxt;
    out_long_r  <= out_long_nxt;
    out_ratio_r <= out_ratio_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign in_ready          = (state_r == gwm_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_short_average = out_short_r;
  assign out_long_average  = out_long_r;
  assign out_macd_ratio    = signed'(out_ratio_r);
  assign out_divide_fault  = out_fault_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_needs_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> fill_r == FILL_FULL)
    else $error("result produced before the window was full");

  a_mac_drained_before_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gwm_pkg::ST_ROUND |-> !rd_vld_r && !prod_vld_r)
    else $error("rounding started with products still in flight");

  a_div_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gwm_pkg::ST_DIV |-> rem_r < avg_l_r)
    else $error("divider remainder not below divisor");

  a_fault_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> out_ratio_r == '0 && out_long_r == '0)
    else $error("divide fault with nonzero ratio or long average");

endmodule

// ----- bench/gaussian_window_macd_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_window_macd_checker: result predictor and scoreboard
// Watches both channels of the MACD block. Keeps its own price window and
// weight tables, predicts each full-window result and compares it field by
// field with what comes out.
// ---------------------------------------------------------------------------
module gaussian_window_macd_checker #(
  parameter int LONG_TAPS  = 26,
  parameter int SHORT_TAPS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_close_price,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        out_short_average,
  input  logic [31:0]        out_long_average,
  input  logic signed [31:0] out_macd_ratio,
  input  logic               out_divide_fault,
  output int                 errors,
  output int                 pending
);

  localparam int SHORT_USED = (SHORT_TAPS < LONG_TAPS) ? SHORT_TAPS : LONG_TAPS;

  typedef struct packed {
    logic [31:0] short_avg;
    logic [31:0] long_avg;
    logic [31:0] ratio;
    logic        fault;
  } macd_result_t;

  macd_result_t    expected_q[$];
  gwm_pkg::price_t window[LONG_TAPS];
  logic [63:0]     long_wt[LONG_TAPS];
  logic [63:0]     short_wt[LONG_TAPS];
  int              head;
  int              fill;

  assign pending = expected_q.size();

  // exp(-3 k^2 / n^2) in Q30: Taylor series of e^-(x/8), then squared 3 times
  function automatic logic [63:0] gauss_raw(input int unsigned k, input int unsigned n);
    logic [63:0] x, y, r, t;
    x = (64'(3 * k * k) << gwm_pkg::Q30_W) / (64'(n) * 64'(n));
    y = x >> 3;
    r = gwm_pkg::Q30_ONE;
    t = gwm_pkg::Q30_ONE;
    for (int i = 1; i <= 10; i++) begin
      t = ((t * y) >> gwm_pkg::Q30_W) / 64'(i);
      if (i % 2 == 1) r = r - t;
      else r = r + t;
    end
    repeat (3) r = (r * r) >> gwm_pkg::Q30_W;
    return r;
  endfunction

  function automatic void build_weights(output logic [63:0] w[LONG_TAPS], input int n);
    logic [63:0] raw[LONG_TAPS];
    logic [63:0] total;
    total = '0;
    for (int k = 0; k < LONG_TAPS; k++) begin
      raw[k] = (k < n) ? gauss_raw(k, n) : '0;
      total += raw[k];
    end
    for (int k = 0; k < LONG_TAPS; k++)
      w[k] = (k < n) ? ((raw[k] << gwm_pkg::FRAC_W) + (total >> 1)) / total : '0;
  endfunction

  // weighted average from the oldest price (at head once the window is full)
  function automatic logic [31:0] window_average(input logic [63:0] w[LONG_TAPS], input int n);
    logic [63:0] acc;
    logic [63:0] rounded;
    acc = '0;
    for (int k = 0; k < n; k++)
      acc += 64'(window[(head + k) % LONG_TAPS]) * w[k];
    rounded = (acc + gwm_pkg::ROUND_BIT) >> gwm_pkg::FRAC_W;
    if (rounded > 64'(gwm_pkg::AVG_MAX)) rounded = 64'(gwm_pkg::AVG_MAX);
    return rounded[31:0];
  endfunction

  function automatic macd_result_t predict_result();
    macd_result_t res;
    logic [63:0]  quo;
    res.short_avg = window_average(short_wt, SHORT_USED);
    res.long_avg  = window_average(long_wt, LONG_TAPS);
    res.fault     = 1'b0;
    res.ratio     = '0;
    if (res.long_avg == 0) begin
      res.fault = 1'b1;
    end else if (res.short_avg >= res.long_avg) begin
      quo = (64'(res.short_avg - res.long_avg) << gwm_pkg::FRAC_W) / 64'(res.long_avg);
      if (quo > 64'(gwm_pkg::RATIO_MAX)) quo = 64'(gwm_pkg::RATIO_MAX);
      res.ratio = quo[31:0];
    end else begin
      quo = (64'(res.long_avg - res.short_avg) << gwm_pkg::FRAC_W) / 64'(res.long_avg);
      if (quo > 64'(gwm_pkg::RATIO_MIN)) quo = 64'(gwm_pkg::RATIO_MIN);
      res.ratio = 32'(64'h1_0000_0000 - quo);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    build_weights(long_wt, LONG_TAPS);
    build_weights(short_wt, SHORT_USED);
  end

  always @(posedge clk) begin : scoreboard
    macd_result_t want;
    if (!rst_n) begin
      head = 0;
      fill = 0;
      expected_q.delete();
    end else begin
      // result side first so a same-cycle input never matches this result
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with none expected, short_average",
                          out_short_average, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_short_average !== want.short_avg)
            report_mismatch("short_average", out_short_average, want.short_avg);
          if (out_long_average !== want.long_avg)
            report_mismatch("long_average", out_long_average, want.long_avg);
          if (out_macd_ratio !== want.ratio)
            report_mismatch("macd_ratio", out_macd_ratio, want.ratio);
          if (out_divide_fault !== want.fault)
            report_mismatch("divide_fault", 32'(out_divide_fault), 32'(want.fault));
        end
      end
      if (in_valid && in_ready) begin
        window[head] = in_close_price;
        head = (head + 1) % LONG_TAPS;
        if (fill < LONG_TAPS) fill++;
        if (fill == LONG_TAPS) expected_q = {expected_q, predict_result()};
      end
    end
  end

endmodule

// ----- bench/gaussian_window_macd_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_window_macd_tb: testbench top for the Gaussian-window MACD block
// Drives price transfers with random gaps, a stalling receiver with one long
// hold-off, and a watchdog; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module gaussian_window_macd_tb;

  localparam int LONG_TAPS      = 26;
  localparam int SHORT_TAPS     = 12;
  localparam int TOTAL_ITEMS    = 1500;
  localparam int HOLD_CYCLES    = 1000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  typedef enum int {
    PK_FULL,
    PK_SMALL,
    PK_MAX,
    PK_ZERO,
    PK_SPIKE,
    PK_PATTERN
  } price_kind_t;

  localparam gwm_pkg::price_t CORNER_PRICES[8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_close_price = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_short_average;
  logic [31:0] out_long_average;
  logic signed [31:0] out_macd_ratio;
  logic        out_divide_fault;

  int errors;
  int pending;
  int items_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  gaussian_window_macd #(
    .LONG_TAPS (LONG_TAPS),
    .SHORT_TAPS(SHORT_TAPS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_close_price   (in_close_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_short_average(out_short_average),
    .out_long_average (out_long_average),
    .out_macd_ratio   (out_macd_ratio),
    .out_divide_fault (out_divide_fault)
  );

  gaussian_window_macd_checker #(
    .LONG_TAPS (LONG_TAPS),
    .SHORT_TAPS(SHORT_TAPS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_close_price   (in_close_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_short_average(out_short_average),
    .out_long_average (out_long_average),
    .out_macd_ratio   (out_macd_ratio),
    .out_divide_fault (out_divide_fault),
    .errors           (errors),
    .pending          (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones; never zero
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic gwm_pkg::price_t pick_price(input price_kind_t kind, input bit first);
    case (kind)
      PK_FULL:  return $urandom;
      PK_SMALL: return ($urandom_range(0, 4) == 0)
                       ? gwm_pkg::price_t'($urandom_range(1, 8)) : '0;
      PK_MAX:   return ($urandom_range(0, 7) == 0) ? gwm_pkg::price_t'($urandom) : '1;
      PK_ZERO:  return '0;
      // a lone price walking through an otherwise empty window
      PK_SPIKE: begin
        if (!first) return '0;
        return $urandom_range(0, 1) ? gwm_pkg::price_t'($urandom)
                                    : gwm_pkg::price_t'($urandom_range(1, 8));
      end
      default:  return $urandom_range(0, 1) ? 32'hAAAA_AAAA : 32'h5555_5555;
    endcase
  endfunction

  // valid stays high across back-to-back transfers; lowered only for a gap
  task automatic send_price(input gwm_pkg::price_t price);
    int gap;
    in_valid       <= 1'b1;
    in_close_price <= price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random ready/stall phases, plus one long hold-off on request
  initial begin : receiver
    int run;
    repeat (8) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 50);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if ($urandom_range(0, 9) < 4) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  // no transfer on either channel for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gaussian_window_macd_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    price_kind_t kind;
    int seg_len;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill with zeros: first full window is a zero long average
    repeat (LONG_TAPS - 1) send_price('0);
    foreach (CORNER_PRICES[i]) send_price(CORNER_PRICES[i]);

    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: kind = PK_FULL;
        4:          kind = PK_SMALL;
        5:          kind = PK_MAX;
        6:          kind = PK_ZERO;
        7, 8:       kind = PK_SPIKE;
        default:    kind = PK_PATTERN;
      endcase
      seg_len = (kind == PK_SPIKE) ? $urandom_range(LONG_TAPS, LONG_TAPS + 14)
                                   : $urandom_range(1, 60);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        if (!hold_req && items_sent >= TOTAL_ITEMS / 2) hold_req <= 1'b1;
        send_price(pick_price(kind, i == 0));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("gaussian_window_macd_tb passed");
    end else begin
      $display("gaussian_window_macd_tb failed");
    end
    $finish;
  end

endmodule
